/* hw/rtl/swl_pkg.sv */
// ----------------------------------------------------------------------------
// swl_pkg
// Shared types and constants of the stopwatch with lap memory and display.
// ----------------------------------------------------------------------------
package swl_pkg;

    // transaction modes
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_SET   = 3'd1;
    localparam logic [2:0] MODE_NEXT  = 3'd2;
    localparam logic [2:0] MODE_CLEAR = 3'd3;
    localparam logic [2:0] MODE_SAVE  = 3'd4;

    // run states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_STOP = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SEC_DIV  = 2'd0;
    localparam logic [1:0] CFG_FRAC_DIV = 2'd1;
    localparam logic [1:0] CFG_REF_DIV  = 2'd2;

    localparam logic [9:0] SEC_DIV_RST  = 10'd1000;
    localparam logic [9:0] FRAC_DIV_RST = 10'd100;
    localparam logic [3:0] REF_DIV_RST  = 4'd3;

    localparam logic [9:0] MASK_PRE   = 10'h3ff;
    localparam logic [9:0] MASK_VAL   = 10'h07f;
    localparam logic [9:0] MASK_REF   = 10'h00f;
    localparam logic [9:0] VAL_LIMIT  = 10'd100;

    // request to the shared increment-and-wrap unit
    typedef struct packed {
        logic [9:0] operand;
        logic [9:0] mask;
        logic [9:0] limit;
        logic [9:0] wrap;
    } step_req_t;

    // slot store write control
    typedef struct packed {
        logic we_sec;
        logic we_frac;
        logic clr;
    } slot_wr_t;

    // decimal digit of a two-digit count for a panel
    function automatic logic [3:0] digit_of(input logic [1:0] panel,
                                            input logic [6:0] secs,
                                            input logic [6:0] frac);
        logic [6:0]  v;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        v     = panel[1] ? frac : secs;
        prod  = 15'(v) * 15'd205;
        tens  = prod[14:11];
        units = v - 7'(tens * 4'd10);
        if (tens >= 4'd10)
        begin
            tens = tens - 4'd10;
        end
        return panel[0] ? units[3:0] : tens;
    endfunction

endpackage

/* hw/rtl/swl_step_unit.sv */
// ----------------------------------------------------------------------------
// swl_step_unit
// Shared increment unit: adds one, masks to width, wraps at a limit.
// ----------------------------------------------------------------------------
module swl_step_unit
    import swl_pkg::*;
(
    input  step_req_t  req,
    output logic [9:0] result
);

    logic [9:0] sum;
    logic [9:0] masked;

    assign sum    = req.operand + 10'd1;
    assign masked = sum & req.mask;
    assign result = (masked >= req.limit) ? req.wrap : masked;

endmodule

/* hw/rtl/swl_slot_store.sv */
// ----------------------------------------------------------------------------
// swl_slot_store
// Lap slot registers: one addressed read port plus a fixed slot 0 output, one write port, clear of all slots at once.
// ----------------------------------------------------------------------------
module swl_slot_store
    import swl_pkg::*;
#(
    parameter int SLOT_COUNT = 5,
    parameter int SLOT_W     = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  slot_wr_t          wr,
    input  logic [SLOT_W-1:0] wr_addr,
    input  logic [6:0]        wr_sec,
    input  logic [6:0]        wr_frac,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [6:0]        rd_sec,
    output logic [6:0]        rd_frac,
    output logic [6:0]        base_sec,
    output logic [6:0]        base_frac
);

    logic [6:0] sec_reg  [SLOT_COUNT];
    logic [6:0] frac_reg [SLOT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                sec_reg[i]  <= '0;
                frac_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (wr.clr)
                begin
                    sec_reg[i]  <= '0;
                    frac_reg[i] <= '0;
                end
                else if (wr_addr == SLOT_W'(i))
                begin
                    if (wr.we_sec)
                    begin
                        sec_reg[i] <= wr_sec;
                    end
                    if (wr.we_frac)
                    begin
                        frac_reg[i] <= wr_frac;
                    end
                end
            end
        end
    end

    always_comb
    begin
        rd_sec  = '0;
        rd_frac = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (rd_addr == SLOT_W'(i))
            begin
                rd_sec  = sec_reg[i];
                rd_frac = frac_reg[i];
            end
        end
    end

    assign base_sec  = sec_reg[0];
    assign base_frac = frac_reg[0];

endmodule

/* hw/rtl/stopwatch_lap_display.sv */
// ----------------------------------------------------------------------------
// stopwatch_lap_display
// sequence: a running tick steps both prescalers, then the fraction and seconds counts;
// others pass refresh or save, or go to finish; show-next scans up to SLOT_COUNT slots
// throughput: one transaction at a time; the sequencer steps one shared increment
// unit, so the next item is taken once the result has been taken
// reset: asynchronous, idle state, all slots, prescalers and counters zero
// ----------------------------------------------------------------------------
module stopwatch_lap_display
    import swl_pkg::*;
#(
    parameter int SLOT_COUNT = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] mode,
    input  logic [1:0] target_state,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       drive_update,
    output logic [1:0] panel,
    output logic [3:0] digit,
    output logic       point_on,
    output logic [1:0] run_state,
    output logic [2:0] shown_slot,
    output logic [6:0] shown_seconds,
    output logic [6:0] shown_fraction
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEC_PRE,
        S_FRAC_PRE,
        S_FRAC_VAL,
        S_SEC_VAL,
        S_REFRESH,
        S_SCAN,
        S_SAVE,
        S_FINISH,
        S_OUT
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [9:0]        sec_div_reg, sec_div_next;
    logic [9:0]        frac_div_reg, frac_div_next;
    logic [3:0]        ref_div_reg, ref_div_next;
    logic [1:0]        mode_state_reg, mode_state_next;
    logic [9:0]        sec_pre_reg, sec_pre_next;
    logic [9:0]        frac_pre_reg, frac_pre_next;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [SLOT_W-1:0] lap_slot_reg, lap_slot_next;
    logic [1:0]        dig_idle_reg, dig_idle_next;
    logic [1:0]        dig_run_reg, dig_run_next;
    logic [1:0]        dig_stop_reg, dig_stop_next;
    logic [3:0]        ref_idle_reg, ref_idle_next;
    logic [3:0]        ref_stop_reg, ref_stop_next;
    logic              drive_pend_reg, drive_pend_next;
    logic              drive_reg, drive_next;
    logic [1:0]        panel_reg, panel_next;
    logic [3:0]        digit_reg, digit_next;
    logic              point_reg, point_next;
    logic [1:0]        run_state_reg, run_state_next;
    logic [2:0]        shown_slot_reg, shown_slot_next;
    logic [6:0]        shown_sec_reg, shown_sec_next;
    logic [6:0]        shown_frac_reg, shown_frac_next;

    step_req_t         step_req;
    logic [9:0]        step_result;
    slot_wr_t          slot_wr;
    logic [SLOT_W-1:0] wr_addr;
    logic [6:0]        wr_sec;
    logic [6:0]        wr_frac;
    logic [SLOT_W-1:0] rd_addr;
    logic [6:0]        rd_sec;
    logic [6:0]        rd_frac;
    logic [6:0]        base_sec;
    logic [6:0]        base_frac;
    logic              in_accept;
    logic [1:0]        fin_panel;

    swl_step_unit u_step
    (
        .req    (step_req),
        .result (step_result)
    );

    swl_slot_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (slot_wr),
        .wr_addr   (wr_addr),
        .wr_sec    (wr_sec),
        .wr_frac   (wr_frac),
        .rd_addr   (rd_addr),
        .rd_sec    (rd_sec),
        .rd_frac   (rd_frac),
        .base_sec  (base_sec),
        .base_frac (base_frac)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);

    // shared unit operand selection
    always_comb
    begin
        step_req = '{operand: 10'(cur_slot_reg), mask: MASK_PRE,
                     limit: 10'(SLOT_COUNT), wrap: '0};
        unique case (state_reg)
            S_SEC_PRE:
            begin
                step_req = '{operand: sec_pre_reg, mask: MASK_PRE,
                             limit: sec_div_reg, wrap: '0};
            end
            S_FRAC_PRE:
            begin
                step_req = '{operand: frac_pre_reg, mask: MASK_PRE,
                             limit: frac_div_reg, wrap: '0};
            end
            S_FRAC_VAL:
            begin
                step_req = '{operand: 10'(rd_frac), mask: MASK_VAL,
                             limit: VAL_LIMIT, wrap: '0};
            end
            S_SEC_VAL:
            begin
                step_req = '{operand: 10'(rd_sec), mask: MASK_VAL,
                             limit: VAL_LIMIT, wrap: '0};
            end
            S_REFRESH:
            begin
                step_req = '{operand: 10'((mode_state_reg == ST_STOP) ? ref_stop_reg
                                                                      : ref_idle_reg),
                             mask: MASK_REF, limit: 10'(ref_div_reg), wrap: '0};
            end
            S_SAVE:
            begin
                // lap slots rotate over 1 .. SLOT_COUNT-1
                step_req = '{operand: 10'(lap_slot_reg), mask: MASK_PRE,
                             limit: 10'(SLOT_COUNT), wrap: 10'd1};
            end
            default:
            begin
            end
        endcase
    end

    assign rd_addr   = (state_reg == S_SCAN) ? SLOT_W'(step_result) : cur_slot_reg;
    assign fin_panel = (mode_state_reg == ST_RUN)  ? dig_run_reg  :
                       (mode_state_reg == ST_STOP) ? dig_stop_reg : dig_idle_reg;

    always_comb
    begin
        state_next      = state_reg;
        sec_div_next    = sec_div_reg;
        frac_div_next   = frac_div_reg;
        ref_div_next    = ref_div_reg;
        mode_state_next = mode_state_reg;
        sec_pre_next    = sec_pre_reg;
        frac_pre_next   = frac_pre_reg;
        cur_slot_next   = cur_slot_reg;
        lap_slot_next   = lap_slot_reg;
        dig_idle_next   = dig_idle_reg;
        dig_run_next    = dig_run_reg;
        dig_stop_next   = dig_stop_reg;
        ref_idle_next   = ref_idle_reg;
        ref_stop_next   = ref_stop_reg;
        drive_pend_next = drive_pend_reg;
        drive_next      = drive_reg;
        panel_next      = panel_reg;
        digit_next      = digit_reg;
        point_next      = point_reg;
        run_state_next  = run_state_reg;
        shown_slot_next = shown_slot_reg;
        shown_sec_next  = shown_sec_reg;
        shown_frac_next = shown_frac_reg;
        slot_wr         = '0;
        wr_addr         = cur_slot_reg;
        wr_sec          = step_result[6:0];
        wr_frac         = step_result[6:0];

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEC_DIV:  sec_div_next  = cfg_data;
                CFG_FRAC_DIV: frac_div_next = cfg_data;
                CFG_REF_DIV:  ref_div_next  = cfg_data[3:0];
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    drive_pend_next = 1'b0;
                    state_next      = S_FINISH;
                    unique case (mode)
                        MODE_TICK:
                        begin
                            state_next = (mode_state_reg == ST_RUN) ? S_SEC_PRE : S_REFRESH;
                        end
                        MODE_SET:
                        begin
                            if (target_state != 2'd3 &&
                                !(target_state == ST_STOP && mode_state_reg == ST_IDLE) &&
                                !(target_state == ST_IDLE && mode_state_reg == ST_RUN))
                            begin
                                mode_state_next = target_state;
                            end
                        end
                        MODE_NEXT:
                        begin
                            if (mode_state_reg == ST_STOP)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            slot_wr.clr = 1'b1;
                        end
                        MODE_SAVE:
                        begin
                            if (mode_state_reg == ST_RUN)
                            begin
                                state_next = S_SAVE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SEC_PRE:
            begin
                sec_pre_next = step_result;
                state_next   = S_FRAC_PRE;
            end
            S_FRAC_PRE:
            begin
                frac_pre_next = step_result;
                state_next    = S_FRAC_VAL;
            end
            S_FRAC_VAL:
            begin
                slot_wr.we_frac = (frac_pre_reg == '0);
                state_next      = S_SEC_VAL;
            end
            S_SEC_VAL:
            begin
                slot_wr.we_sec  = (sec_pre_reg == '0);
                drive_pend_next = 1'b1;
                state_next      = S_FINISH;
            end
            S_REFRESH:
            begin
                if (mode_state_reg == ST_STOP)
                begin
                    ref_stop_next = step_result[3:0];
                end
                else
                begin
                    ref_idle_next = step_result[3:0];
                end
                drive_pend_next = (step_result == '0);
                state_next      = S_FINISH;
            end
            S_SCAN:
            begin
                // halt at slot 0 or at a slot with both counts nonzero
                cur_slot_next = SLOT_W'(step_result);
                if (step_result == '0 || (rd_sec != '0 && rd_frac != '0))
                begin
                    state_next = S_FINISH;
                end
            end
            S_SAVE:
            begin
                lap_slot_next   = SLOT_W'(step_result);
                wr_addr         = SLOT_W'(step_result);
                wr_sec          = base_sec;
                wr_frac         = base_frac;
                slot_wr.we_sec  = 1'b1;
                slot_wr.we_frac = 1'b1;
                state_next      = S_FINISH;
            end
            S_FINISH:
            begin
                drive_next      = drive_pend_reg;
                panel_next      = drive_pend_reg ? fin_panel : 2'd0;
                digit_next      = (drive_pend_reg && mode_state_reg != ST_IDLE)
                                  ? digit_of(fin_panel, rd_sec, rd_frac) : 4'd0;
                point_next      = drive_pend_reg && (fin_panel == 2'd1);
                run_state_next  = mode_state_reg;
                shown_slot_next = 3'(cur_slot_reg);
                shown_sec_next  = rd_sec;
                shown_frac_next = rd_frac;
                if (drive_pend_reg)
                begin
                    if (mode_state_reg == ST_RUN)
                    begin
                        dig_run_next = dig_run_reg + 2'd1;
                    end
                    else if (mode_state_reg == ST_STOP)
                    begin
                        dig_stop_next = dig_stop_reg + 2'd1;
                    end
                    else
                    begin
                        dig_idle_next = dig_idle_reg + 2'd1;
                    end
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sec_div_reg    <= SEC_DIV_RST;
            frac_div_reg   <= FRAC_DIV_RST;
            ref_div_reg    <= REF_DIV_RST;
            mode_state_reg <= ST_IDLE;
            sec_pre_reg    <= '0;
            frac_pre_reg   <= '0;
            cur_slot_reg   <= '0;
            lap_slot_reg   <= '0;
            dig_idle_reg   <= '0;
            dig_run_reg    <= '0;
            dig_stop_reg   <= '0;
            ref_idle_reg   <= '0;
            ref_stop_reg   <= '0;
            drive_pend_reg <= 1'b0;
            drive_reg      <= 1'b0;
            panel_reg      <= '0;
            digit_reg      <= '0;
            point_reg      <= 1'b0;
            run_state_reg  <= ST_IDLE;
            shown_slot_reg <= '0;
            shown_sec_reg  <= '0;
            shown_frac_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sec_div_reg    <= sec_div_next;
            frac_div_reg   <= frac_div_next;
            ref_div_reg    <= ref_div_next;
            mode_state_reg <= mode_state_next;
            sec_pre_reg    <= sec_pre_next;
            frac_pre_reg   <= frac_pre_next;
            cur_slot_reg   <= cur_slot_next;
            lap_slot_reg   <= lap_slot_next;
            dig_idle_reg   <= dig_idle_next;
            dig_run_reg    <= dig_run_next;
            dig_stop_reg   <= dig_stop_next;
            ref_idle_reg   <= ref_idle_next;
            ref_stop_reg   <= ref_stop_next;
            drive_pend_reg <= drive_pend_next;
            drive_reg      <= drive_next;
            panel_reg      <= panel_next;
            digit_reg      <= digit_next;
            point_reg      <= point_next;
            run_state_reg  <= run_state_next;
            shown_slot_reg <= shown_slot_next;
            shown_sec_reg  <= shown_sec_next;
            shown_frac_reg <= shown_frac_next;
        end
    end

    assign drive_update   = drive_reg;
    assign panel          = panel_reg;
    assign digit          = digit_reg;
    assign point_on       = point_reg;
    assign run_state      = run_state_reg;
    assign shown_slot     = shown_slot_reg;
    assign shown_seconds  = shown_sec_reg;
    assign shown_fraction = shown_frac_reg;

`ifndef SYNTHESIS
    // stopped is never entered straight from idle
    a_no_idle_to_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_state_reg == ST_IDLE) |=> (mode_state_reg != ST_STOP))
        else $error("stopped entered from idle");

    // slot index stays inside the slot range
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_slot_reg) < SLOT_COUNT) && (32'(lap_slot_reg) < SLOT_COUNT))
        else $error("slot index out of range");

    // a pending result blocks new input transactions
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while result pending");

    // no digit driven means a blank panel selection
    a_blank_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !drive_update) |-> (panel == 2'd0 && digit == 4'd0 && !point_on))
        else $error("panel data without drive");

    // digits are decimal
    a_digit_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit <= 4'd9))
        else $error("digit out of range");
`endif

endmodule
